FILE: src/uvtg_pkg.sv
// ----------------------------------------------------------------------------
// UUID v1 timestamp generator package
// Shared widths, constants and types for the timestamp generator.
// ----------------------------------------------------------------------------
package uvtg_pkg;

    localparam int TIME_W    = 60;
    localparam int STAMP_W   = 64;
    localparam int BORROW_W  = 32;
    localparam int NODE_W    = 48;
    localparam int PROC_W    = 16;
    localparam int FIELD16_W = 16;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 128;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 48;

    // Ticks of 100 ns from the Gregorian reform to 1970.
    localparam logic [STAMP_W-1:0] EPOCH_DAYS    = 64'd141427;
    localparam logic [STAMP_W-1:0] TICKS_PER_DAY = 64'd864000000000;
    localparam logic [STAMP_W-1:0] EPOCH_OFFSET  = EPOCH_DAYS * TICKS_PER_DAY;

    localparam logic [FIELD16_W-1:0] VERSION_TAG = 16'h1000;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_TAG  = 1'b1;

    typedef logic [STAMP_W-1:0]  t_stamp;
    typedef logic [BORROW_W-1:0] t_borrow;

    typedef struct packed {
        logic   restart;
        t_stamp stamp;
    } t_core_status;

endpackage

FILE: src/uuid_v1_timestamp_generator.sv
// ----------------------------------------------------------------------------
// UUID v1 timestamp generator
// Turns wall-time requests into version 1 identifier fields.
// An input beat passes through the base register and then the output register.
// Throughput is one beat per cycle while the output is not stalled; the stamp update is combinational.
// Synchronous active-low reset clears the last stamp, the borrow count,
// both configuration registers and all valid flags.
// ----------------------------------------------------------------------------
module uuid_v1_timestamp_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [59:0] system_time, [63:60] zero
    input  logic [uvtg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] stamp bits 31..0, [47:32] stamp bits 47..32, [63:48] time_high_version,
    // [79:64] process_field, [127:80] node_field
    output logic [uvtg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [uvtg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uvtg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import uvtg_pkg::*;

    logic                r_s1_valid;
    t_stamp              r_base;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [NODE_W-1:0]   r_node_address;
    logic [PROC_W-1:0]   r_process_tag;

    logic                w_out_en;
    logic                w_advance;
    t_core_status        w_status;

    assign w_out_en      = !r_out_valid || m_axis_tready;
    assign w_advance     = r_s1_valid && w_out_en;
    assign s_axis_tready = !r_s1_valid || w_out_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= '0;
            r_process_tag  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NODE_ADDRESS: r_node_address <= i_cfg_data[NODE_W-1:0];
                REG_PROCESS_TAG:  r_process_tag  <= i_cfg_data[PROC_W-1:0];
                default:          r_process_tag  <= r_process_tag;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_base <= {{(STAMP_W-TIME_W){1'b0}}, s_axis_tdata[TIME_W-1:0]} + EPOCH_OFFSET;
        end
    end

    uvtg_stamp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_base    (r_base),
        .o_status  (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {r_node_address,
                           r_process_tag,
                           w_status.stamp[STAMP_W-1:48] | VERSION_TAG,
                           w_status.stamp[47:32],
                           w_status.stamp[31:0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_stamp_not_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> (w_status.stamp >= r_base))
        else $error("stamp fell below the epoch-adjusted time");

    a_restart_means_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> (w_status.restart == (w_status.stamp == r_base)))
        else $error("restart flag disagrees with the chosen stamp");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced beat did not reach the output register");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || !r_s1_valid) |-> s_axis_tready)
        else $error("input stalled while the pipeline has room");

endmodule

FILE: src/uvtg_stamp_core.sv
// ----------------------------------------------------------------------------
// UUID v1 stamp core
// Holds the last stamp and the borrowed tick count and picks the next stamp.
// ----------------------------------------------------------------------------
module uvtg_stamp_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  uvtg_pkg::t_stamp      i_base,
    output uvtg_pkg::t_core_status o_status
);
    import uvtg_pkg::*;

    t_stamp  r_last_stamp;
    t_borrow r_borrow;
    t_stamp  n_last_stamp;
    t_borrow n_borrow;

    logic [STAMP_W:0]   w_diff;
    t_stamp             w_last_inc;
    logic               w_ahead;
    logic               w_restart;

    // The stamp stays at last + 1 when the base is not past the last stamp
    // and the borrow can cover the gap; otherwise it restarts from the base.
    always_comb begin
        w_diff     = {1'b0, r_last_stamp} - {1'b0, i_base};
        w_last_inc = r_last_stamp + t_stamp'(1);
        w_ahead    = !w_diff[STAMP_W]
                   && (w_diff[STAMP_W-1:BORROW_W] == '0)
                   && (w_diff[BORROW_W-1:0] != '1)
                   && ({1'b0, r_borrow} >= {1'b0, w_diff[BORROW_W-1:0]});
        w_restart  = !w_ahead;
        if (w_ahead) begin
            n_last_stamp = w_last_inc;
            n_borrow     = w_diff[BORROW_W-1:0] + t_borrow'(1);
        end else begin
            n_last_stamp = i_base;
            n_borrow     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp <= '0;
            r_borrow     <= '0;
        end else if (i_advance) begin
            r_last_stamp <= n_last_stamp;
            r_borrow     <= n_borrow;
        end
    end

    assign o_status.restart = w_restart;
    assign o_status.stamp   = n_last_stamp;

endmodule
